>>> sv/ipv4dq_pkg.sv
// ----------------------------------------------------------------------------
// ipv4dq_pkg
// Types and constants shared by the dotted-quad parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv4dq_pkg;

  typedef enum logic [2:0] {
    ERR_NONE = 3'd0,
    ERR_CHAR = 3'd1,
    ERR_PART = 3'd2,
    ERR_MANY = 3'd3,
    ERR_BIG  = 3'd4,
    ERR_ZERO = 3'd5,
    ERR_FEW  = 3'd6
  } err_t;

  localparam logic [7:0] CHAR_DOT  = 8'h2E;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic [9:0] VALUE_SAT     = 10'd1023;
  localparam logic [9:0] OCTET_MAX     = 10'd255;
  localparam logic [9:0] TWO_DIGIT_MAX = 10'd99;
  localparam logic [9:0] ONE_DIGIT_MAX = 10'd9;
  localparam logic [2:0] DIGITS_SAT    = 3'd4;
  localparam logic [2:0] DIGITS_MAX    = 3'd3;
  localparam logic [2:0] PARTS_NEEDED  = 3'd4;

  localparam logic [7:0] OCTET_LOOPBACK  = 8'd127;
  localparam logic [7:0] OCTET_MULTICAST = 8'd224;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  value;
    logic [2:0]  digits;
    logic [2:0]  count;
    logic [31:0] octets;
    err_t        err;
  } parse_state_t;

  typedef struct packed {
    logic        ok;
    err_t        error_cause;
    logic [31:0] address;
    logic        routable;
  } result_t;

endpackage

`default_nettype wire

>>> sv/ipv4dq_if.sv
// ----------------------------------------------------------------------------
// ipv4dq interfaces
// Valid/ready channels for characters in and parse results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipv4dq_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface ipv4dq_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [2:0]  error_cause;
  logic [31:0] address;
  logic        routable;

  modport source (output valid, output ok, output error_cause, output address,
                  output routable, input ready);
  modport sink   (input valid, input ok, input error_cause, input address,
                  input routable, output ready);
endinterface

`default_nettype wire

>>> sv/ipv4dq_in_reg.sv
// ----------------------------------------------------------------------------
// ipv4dq_in_reg
// Input register stage: holds one character until the parse stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4dq_in_reg (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  ipv4dq_in_if.sink                 in_ch,
  input  wire logic                 take,
  output logic                      hold_valid,
  output ipv4dq_pkg::in_item_t      hold_item
);

  logic                 valid_r;
  logic                 valid_nxt;
  ipv4dq_pkg::in_item_t item_r;
  logic                 load;

  assign in_ch.ready = !valid_r || take;
  assign load        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.char_code <= in_ch.char_code;
      item_r.is_last   <= in_ch.is_last;
    end
  end

  assign hold_valid = valid_r;
  assign hold_item  = item_r;

endmodule

`default_nettype wire

>>> sv/ipv4dq_step.sv
// ----------------------------------------------------------------------------
// ipv4dq_step
// Per-character parse update, end-of-string close and result formation.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4dq_step (
  input  wire ipv4dq_pkg::parse_state_t st,
  input  wire ipv4dq_pkg::in_item_t     item,
  output ipv4dq_pkg::parse_state_t      st_nxt,
  output ipv4dq_pkg::result_t           res
);

  function automatic ipv4dq_pkg::parse_state_t close_part(
    input ipv4dq_pkg::parse_state_t s
  );
    ipv4dq_pkg::parse_state_t n;
    n = s;
    if (s.err == ipv4dq_pkg::ERR_NONE) begin
      if (s.digits == 3'd0 || s.digits > ipv4dq_pkg::DIGITS_MAX) begin
        n.err = ipv4dq_pkg::ERR_PART;
      end else if (s.count >= ipv4dq_pkg::PARTS_NEEDED) begin
        n.err = ipv4dq_pkg::ERR_MANY;
      end else if (s.value > ipv4dq_pkg::OCTET_MAX) begin
        n.err = ipv4dq_pkg::ERR_BIG;
      end else if ((s.value <= ipv4dq_pkg::ONE_DIGIT_MAX && s.digits != 3'd1) ||
                   (s.value > ipv4dq_pkg::ONE_DIGIT_MAX &&
                    s.value <= ipv4dq_pkg::TWO_DIGIT_MAX && s.digits != 3'd2)) begin
        n.err = ipv4dq_pkg::ERR_ZERO;
      end else begin
        // The count is below four here, so its low two bits pick the octet.
        case (s.count[1:0])
          2'd0:    n.octets[31:24] = s.octets[31:24] | s.value[7:0];
          2'd1:    n.octets[23:16] = s.octets[23:16] | s.value[7:0];
          2'd2:    n.octets[15:8]  = s.octets[15:8]  | s.value[7:0];
          default: n.octets[7:0]   = s.octets[7:0]   | s.value[7:0];
        endcase
        n.value  = '0;
        n.digits = '0;
        n.count  = s.count + 3'd1;
      end
    end
    return n;
  endfunction

  function automatic ipv4dq_pkg::parse_state_t take_char(
    input ipv4dq_pkg::parse_state_t s,
    input logic [7:0]               ch
  );
    ipv4dq_pkg::parse_state_t n;
    logic [13:0]              v;
    n = s;
    // Times ten as x*8 + x*2; for a digit character the low nibble is its value.
    v = {1'b0, s.value, 3'b000} + {3'b000, s.value, 1'b0} + {10'd0, ch[3:0]};
    if (s.err == ipv4dq_pkg::ERR_NONE) begin
      if (ch == ipv4dq_pkg::CHAR_DOT) begin
        n = close_part(s);
      end else if (ch < ipv4dq_pkg::CHAR_ZERO || ch > ipv4dq_pkg::CHAR_NINE) begin
        n.err = ipv4dq_pkg::ERR_CHAR;
      end else begin
        n.value = (v > {4'd0, ipv4dq_pkg::VALUE_SAT}) ? ipv4dq_pkg::VALUE_SAT : v[9:0];
        if (s.digits < ipv4dq_pkg::DIGITS_SAT) begin
          n.digits = s.digits + 3'd1;
        end
      end
    end
    return n;
  endfunction

  ipv4dq_pkg::parse_state_t after_char;
  ipv4dq_pkg::parse_state_t at_end;
  logic [7:0]               first_octet;

  always_comb begin
    after_char = take_char(st, item.char_code);
    // The end of the string closes one more part, like a trailing dot.
    at_end = close_part(after_char);
    if (at_end.err == ipv4dq_pkg::ERR_NONE && at_end.count != ipv4dq_pkg::PARTS_NEEDED) begin
      at_end.err = ipv4dq_pkg::ERR_FEW;
    end

    res.ok          = (at_end.err == ipv4dq_pkg::ERR_NONE);
    res.error_cause = at_end.err;
    res.address     = res.ok ? at_end.octets : 32'd0;
    first_octet     = res.address[31:24];
    res.routable    = res.ok && first_octet != 8'd0 &&
                      first_octet != ipv4dq_pkg::OCTET_LOOPBACK &&
                      first_octet < ipv4dq_pkg::OCTET_MULTICAST;

    st_nxt = item.is_last ? '0 : after_char;
  end

endmodule

`default_nettype wire

>>> sv/ipv4_dotted_quad_parser_unit.sv
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_parser_unit
// Parses an IPv4 dotted-decimal address, one ASCII character per transfer.
// ----------------------------------------------------------------------------
// Characters enter on in_ch (valid/ready), one per transfer, with is_last set
// on the final character of each address string. Characters before the last
// produce nothing; the last one produces exactly one transfer on out_ch with
// ok, the first error cause, the address (zero unless ok) and a routable flag.
// A character is captured in an input register, then the combinational parse logic
// updates the running state and, for the last character, loads the result
// register. out_ch.valid rises once the last character has passed the input
// register and then the result register; one character is accepted every
// cycle, unless a final character waits for the result register to free.
// When out_ch stalls with a result waiting, further non-final characters keep
// flowing; a final character waits in the input register until the result
// register frees, and in_ch.ready drops only then. Synchronous reset (rst_n
// low) empties both registers and clears the parse state, so the next
// character starts a new string. After each string the state clears itself.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_dotted_quad_parser_unit (
  input  wire logic     clk,
  input  wire logic     rst_n,
  ipv4dq_in_if.sink     in_ch,
  ipv4dq_out_if.source  out_ch
);

  logic                     hold_valid;
  ipv4dq_pkg::in_item_t     hold_item;
  logic                     advance;
  logic                     out_free;
  ipv4dq_pkg::parse_state_t st_r;
  ipv4dq_pkg::parse_state_t st_nxt;
  ipv4dq_pkg::result_t      step_res;
  ipv4dq_pkg::result_t      res_r;
  logic                     out_valid_r;
  logic                     out_valid_nxt;

  assign out_free = !out_valid_r || out_ch.ready;
  assign advance  = hold_valid && (!hold_item.is_last || out_free);

  ipv4dq_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (advance),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  ipv4dq_step u_step (
    .st     (st_r),
    .item   (hold_item),
    .st_nxt (st_nxt),
    .res    (step_res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && hold_item.is_last) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hold_item.is_last) begin
      res_r <= step_res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.ok          = res_r.ok;
  assign out_ch.error_cause = res_r.error_cause;
  assign out_ch.address     = res_r.address;
  assign out_ch.routable    = res_r.routable;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.count <= ipv4dq_pkg::PARTS_NEEDED)
    else $error("part count beyond four");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    advance && hold_item.is_last |=> st_r == '0)
    else $error("parse state not cleared after final character");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(advance && hold_item.is_last))
    else $error("result appeared without a final character");

  a_ok_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.ok == (res_r.error_cause == ipv4dq_pkg::ERR_NONE)) &&
                    (!res_r.routable || res_r.ok))
    else $error("result flags disagree with error cause");

  a_last_waits: assert property (@(posedge clk) disable iff (!rst_n)
    hold_valid && hold_item.is_last && out_valid_r && !out_ch.ready |-> !advance)
    else $error("final character processed while result slot is full");

endmodule

`default_nettype wire
